>>> hdl/i2cmbw_pkg.sv
// Package for the I2C master byte writer: shared types, codes and widths.
// Used by every module under hdl; depends on nothing.
package i2cmbw_pkg;

    // Bits shifted out per byte
    localparam int DATA_BITS = 8;
    localparam int BITS_W    = $clog2(DATA_BITS + 1);

    // Phase length register
    localparam int               TICK_W      = 16;
    localparam logic [TICK_W-1:0] PHASE_RESET = 16'd4;

    // Stream word widths (padded to whole bytes)
    localparam int IN_W  = 16;
    localparam int OUT_W = 8;

    // Command opcodes
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_PROBE = 2'd3
    } t_op;

    // Bus phases, one-hot
    typedef enum logic [8:0] {
        PH_IDLE   = 9'b000000001,
        PH_ST_HI  = 9'b000000010,
        PH_ST_LO  = 9'b000000100,
        PH_SP_LO  = 9'b000001000,
        PH_SP_HI  = 9'b000010000,
        PH_WR_SET = 9'b000100000,
        PH_WR_CLK = 9'b001000000,
        PH_AK_SET = 9'b010000000,
        PH_AK_CLK = 9'b100000000
    } t_phase;

    // One decoded tick word, as queued between front and back
    typedef struct packed {
        logic                 cmd_valid;
        t_op                  op;
        logic [DATA_BITS-1:0] load_byte;  // byte to shift, already aligned
        logic                 sda_in;
    } t_item;

    // Queue status seen by the front and back
    typedef struct packed {
        logic head_valid;
        logic full;
    } t_q_status;

    // One result word
    typedef struct packed {
        logic nack;
        logic done_res;
        logic busy_res;
        logic sda_drive;
        logic sda_level;
        logic scl_level;
    } t_result;

endpackage

>>> hdl/i2cmbw_front.sv
// Front end: accepts tick words from the input stream and decodes them.
// Depends on i2cmbw_pkg; feeds i2cmbw_queue.
module i2cmbw_front (
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [0] cmd_valid, [2:1] opcode, [10:3] byte_or_address, [11] sda_in
    input  logic [i2cmbw_pkg::IN_W-1:0]     s_axis_tdata,
    input  i2cmbw_pkg::t_q_status           i_q_status,
    output logic                            o_push,
    output i2cmbw_pkg::t_item               o_item
);

    logic [i2cmbw_pkg::DATA_BITS-1:0] w_val;
    i2cmbw_pkg::t_op                  w_op;

    assign w_val = s_axis_tdata[10:3];
    assign w_op  = i2cmbw_pkg::t_op'(s_axis_tdata[2:1]);

    // Take a word whenever the queue has room
    assign s_axis_tready = !i_q_status.full;
    assign o_push        = s_axis_tvalid && s_axis_tready;

    // Decode; a probe sends the address shifted up with the write bit clear
    always_comb begin
        o_item.cmd_valid = s_axis_tdata[0];
        o_item.op        = w_op;
        o_item.sda_in    = s_axis_tdata[11];
        if (w_op == i2cmbw_pkg::OP_PROBE) begin
            o_item.load_byte = {w_val[i2cmbw_pkg::DATA_BITS-2:0], 1'b0};
        end else begin
            o_item.load_byte = w_val;
        end
    end

endmodule

>>> hdl/i2cmbw_queue.sv
// Two-entry queue between the decoding front end and the bus sequencer.
// Depends on i2cmbw_pkg.
module i2cmbw_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  i2cmbw_pkg::t_item     i_item,
    input  logic                  i_pop,
    output i2cmbw_pkg::t_item     o_item,
    output i2cmbw_pkg::t_q_status o_status
);

    i2cmbw_pkg::t_item r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;

    assign o_item              = r_mem[r_rd_ptr];
    assign o_status.head_valid = (r_count != 2'd0);
    assign o_status.full       = (r_count == 2'd2);

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

>>> hdl/i2cmbw_back.sv
// Back end: I2C bus sequencer, one tick word per step, with output register.
// Depends on i2cmbw_pkg; reads from i2cmbw_queue.
module i2cmbw_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [i2cmbw_pkg::TICK_W-1:0]       i_phase_ticks,
    input  i2cmbw_pkg::t_q_status               i_q_status,
    input  i2cmbw_pkg::t_item                   i_item,
    output logic                                o_pop,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res, [5] nack
    output logic [i2cmbw_pkg::OUT_W-1:0]        m_axis_tdata
);

    localparam int TW = i2cmbw_pkg::TICK_W;
    localparam int DW = i2cmbw_pkg::DATA_BITS;
    localparam int BW = i2cmbw_pkg::BITS_W;

    i2cmbw_pkg::t_phase r_phase, n_phase;
    logic [TW-1:0]      r_tick, n_tick;
    logic [DW-1:0]      r_shift, n_shift;
    logic [BW-1:0]      r_bits, n_bits;
    i2cmbw_pkg::t_op    r_op, n_op;
    logic               r_ack, n_ack;
    logic               r_scl, n_scl;
    logic               r_sda, n_sda;
    logic               r_out_valid;
    i2cmbw_pkg::t_result r_out, n_out;
    logic [TW-1:0]      w_limit;
    logic               w_done;

    // Step when a word waits and the output slot is free or draining
    assign o_pop   = i_q_status.head_valid && (!r_out_valid || m_axis_tready);
    assign w_limit = (i_phase_ticks == '0) ? TW'(1) : i_phase_ticks;

    // Next bus state for one tick
    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_shift = r_shift;
        n_bits  = r_bits;
        n_op    = r_op;
        n_ack   = r_ack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        w_done  = 1'b0;
        if (r_phase == i2cmbw_pkg::PH_IDLE) begin
            if (i_item.cmd_valid) begin
                n_op   = i_item.op;
                n_tick = TW'(1);
                unique case (i_item.op)
                    i2cmbw_pkg::OP_START: begin
                        n_phase = i2cmbw_pkg::PH_ST_HI;
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                    end
                    i2cmbw_pkg::OP_STOP: begin
                        n_phase = i2cmbw_pkg::PH_SP_LO;
                        n_scl   = 1'b0;
                        n_sda   = 1'b0;
                    end
                    i2cmbw_pkg::OP_WRITE: begin
                        n_shift = i_item.load_byte;
                        n_bits  = BW'(DW);
                        n_phase = i2cmbw_pkg::PH_WR_SET;
                        n_sda   = i_item.load_byte[DW-1];
                    end
                    default: begin
                        n_shift = i_item.load_byte;
                        n_bits  = BW'(DW);
                        n_phase = i2cmbw_pkg::PH_ST_HI;
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                    end
                endcase
            end
        end else if (r_tick < w_limit) begin
            n_tick = r_tick + TW'(1);
        end else begin
            n_tick = TW'(1);
            unique case (r_phase)
                i2cmbw_pkg::PH_ST_HI: begin
                    n_phase = i2cmbw_pkg::PH_ST_LO;
                    n_sda   = 1'b0;
                end
                i2cmbw_pkg::PH_ST_LO: begin
                    n_scl = 1'b0;
                    if (r_op == i2cmbw_pkg::OP_PROBE) begin
                        n_phase = i2cmbw_pkg::PH_WR_SET;
                        n_sda   = r_shift[DW-1];
                    end else begin
                        w_done = 1'b1;
                    end
                end
                i2cmbw_pkg::PH_SP_LO: begin
                    n_phase = i2cmbw_pkg::PH_SP_HI;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                end
                i2cmbw_pkg::PH_WR_SET: begin
                    n_phase = i2cmbw_pkg::PH_WR_CLK;
                    n_scl   = 1'b1;
                end
                i2cmbw_pkg::PH_WR_CLK: begin
                    n_scl   = 1'b0;
                    n_shift = {r_shift[DW-2:0], 1'b0};
                    n_bits  = r_bits - BW'(1);
                    if (r_bits == BW'(1)) begin
                        n_phase = i2cmbw_pkg::PH_AK_SET;
                        n_sda   = 1'b1;
                    end else begin
                        n_phase = i2cmbw_pkg::PH_WR_SET;
                        n_sda   = r_shift[DW-2];
                    end
                end
                i2cmbw_pkg::PH_AK_SET: begin
                    n_phase = i2cmbw_pkg::PH_AK_CLK;
                    n_scl   = 1'b1;
                    n_ack   = i_item.sda_in;
                end
                i2cmbw_pkg::PH_AK_CLK: begin
                    n_scl = 1'b0;
                    if (r_op == i2cmbw_pkg::OP_PROBE) begin
                        n_phase = i2cmbw_pkg::PH_SP_LO;
                        n_sda   = 1'b0;
                    end else begin
                        w_done = 1'b1;
                    end
                end
                default: begin
                    w_done = 1'b1;
                end
            endcase
            if (w_done) begin
                n_phase = i2cmbw_pkg::PH_IDLE;
                n_tick  = '0;
            end
        end
    end

    // Result word for this tick
    always_comb begin
        n_out.scl_level = n_scl;
        n_out.sda_level = n_sda;
        n_out.sda_drive = !((n_phase == i2cmbw_pkg::PH_AK_SET) ||
                            (n_phase == i2cmbw_pkg::PH_AK_CLK));
        n_out.busy_res  = (n_phase != i2cmbw_pkg::PH_IDLE);
        n_out.done_res  = w_done;
        n_out.nack      = w_done && ((r_op == i2cmbw_pkg::OP_WRITE) ||
                                     (r_op == i2cmbw_pkg::OP_PROBE)) && n_ack;
    end

    // Bus state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2cmbw_pkg::PH_IDLE;
            r_tick  <= '0;
            r_shift <= '0;
            r_bits  <= '0;
            r_op    <= i2cmbw_pkg::OP_START;
            r_ack   <= 1'b1;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_shift <= n_shift;
            r_bits  <= n_bits;
            r_op    <= n_op;
            r_ack   <= n_ack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out};

endmodule

>>> hdl/i2c_master_byte_writer_unit.sv
// Top level of the I2C master byte writer: front end, queue and bus sequencer.
// Depends on i2cmbw_pkg, i2cmbw_front, i2cmbw_queue and i2cmbw_back.
//
// Usage:
//   Each word on the s_axis stream is one bus tick. It carries an optional
//   command (start, stop, write byte, probe address) that is taken only while
//   the bus is idle, plus the sampled SDA level. For every input word exactly
//   one result word leaves on m_axis: SCL and SDA levels, SDA drive enable,
//   busy, done and the acknowledge result.
//   i_cfg_we / i_cfg_wdata set the phase length in ticks (reset 4, 0 acts
//   as 1); write it only while no word is in flight. A shorter length written
//   mid-phase ends that phase as soon as its elapsed ticks reach it.
// Data path and throughput:
//   A word accepted on s_axis passes the queue and the output register
//   before its result word appears on m_axis; one word per cycle is
//   sustained while m_axis_tready stays high. The sequencer steps once per
//   cycle while the output slot is free, limited by its single phase/tick update loop.
// Reset and stalls:
//   i_rst_n (synchronous, active low) empties the queue and returns the bus
//   to idle with SCL and SDA high. When m_axis stalls, the result register
//   holds, the sequencer pauses and the two-word queue fills, then
//   s_axis_tready drops.
module i2c_master_byte_writer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [i2cmbw_pkg::TICK_W-1:0]       i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] cmd_valid, [2:1] opcode, [10:3] byte_or_address, [11] sda_in
    input  logic [i2cmbw_pkg::IN_W-1:0]         s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res, [5] nack
    output logic [i2cmbw_pkg::OUT_W-1:0]        m_axis_tdata
);

    logic [i2cmbw_pkg::TICK_W-1:0] r_phase_ticks;
    i2cmbw_pkg::t_q_status         w_q_status;
    i2cmbw_pkg::t_item             w_push_item;
    i2cmbw_pkg::t_item             w_head_item;
    logic                          w_push;
    logic                          w_pop;

    // Phase length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= i2cmbw_pkg::PHASE_RESET;
        end else if (i_cfg_we) begin
            r_phase_ticks <= i_cfg_wdata;
        end
    end

    i2cmbw_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_q_status    (w_q_status),
        .o_push        (w_push),
        .o_item        (w_push_item)
    );

    i2cmbw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_item   (w_head_item),
        .o_status (w_q_status)
    );

    i2cmbw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_phase_ticks (r_phase_ticks),
        .i_q_status    (w_q_status),
        .i_item        (w_head_item),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // A finishing tick never reports busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tdata[3])
        else $error("done reported while busy");

    // nack only reported on a finishing tick
    a_nack_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[4])
        else $error("nack without done");

    // SDA is only released inside a command
    a_release_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[3])
        else $error("SDA released while idle");

    // Sequencer only steps on a queued word
    a_pop_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_status.head_valid)
        else $error("sequencer stepped on an empty queue");

endmodule
